FILE: src/bsc_pkg.sv
// Shared types, constants and helpers for the barometric compensation block.
// No dependencies; used by every module in src.
package bsc_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned RawW  = 24;
  localparam int unsigned CfgAw = 3;

  localparam logic [CfgAw-1:0] REG_OSS   = 3'd0;
  localparam logic [CfgAw-1:0] REG_AC1_2 = 3'd1;
  localparam logic [CfgAw-1:0] REG_AC3_4 = 3'd2;
  localparam logic [CfgAw-1:0] REG_AC5_6 = 3'd3;
  localparam logic [CfgAw-1:0] REG_B1_B2 = 3'd4;
  localparam logic [CfgAw-1:0] REG_MC_MD = 3'd5;

  localparam logic [WordW-1:0] K_B6_OFS  = 32'd4000;
  localparam logic [WordW-1:0] K_X1_MUL  = 32'd3038;
  localparam logic [WordW-1:0] K_X2_MUL  = 32'hFFFF_E343;  // -7357
  localparam logic [WordW-1:0] K_P_OFS   = 32'd3791;
  localparam logic [WordW-1:0] K_B7_MUL  = 32'd50000;
  localparam logic [WordW-1:0] K_B4_OFS  = 32'd32768;
  localparam logic [WordW-1:0] K_SIGN    = 32'h8000_0000;

  localparam logic [0:0] KIND_TEMP  = 1'b0;
  localparam logic [0:0] KIND_PRESS = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT  = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  typedef enum logic [3:0] {
    ST_T_MUL  = 4'd0,
    ST_T_DIV  = 4'd1,
    ST_P_SQ   = 4'd2,
    ST_P_X1   = 4'd3,
    ST_P_B3   = 4'd4,
    ST_P_X1B  = 4'd5,
    ST_P_X2B  = 4'd6,
    ST_P_B4   = 4'd7,
    ST_P_B7   = 4'd8,
    ST_P_DIV  = 4'd9,
    ST_P_SQP  = 4'd10,
    ST_P_X1C  = 4'd11,
    ST_P_X2C  = 4'd12
  } step_t;

  function automatic logic [WordW-1:0] asr(input logic [WordW-1:0] v, input logic [4:0] s);
    return WordW'($signed(v) >>> s);
  endfunction

  function automatic logic [WordW-1:0] hi_s(input logic [WordW-1:0] w);
    return {{16{w[31]}}, w[31:16]};
  endfunction

  function automatic logic [WordW-1:0] lo_s(input logic [WordW-1:0] w);
    return {{16{w[15]}}, w[15:0]};
  endfunction

endpackage

FILE: src/bsc_mul.sv
// Bit-serial shift-add multiplier, low 32 bits of the product.
// Depends on bsc_pkg. One multiplier bit per cycle, stops once it runs out of ones.
module bsc_mul (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [bsc_pkg::WordW-1:0] op_a,
  input  logic [bsc_pkg::WordW-1:0] op_b,
  output logic                     done,
  output logic [bsc_pkg::WordW-1:0] prod
);

  logic                      busy_r;
  logic [bsc_pkg::WordW-1:0] a_r, b_r, acc_r;

  assign done = busy_r && (b_r == '0);
  assign prod = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= op_a;
      b_r   <= op_b;
      acc_r <= '0;
    end else if (busy_r && (b_r != '0)) begin
      if (b_r[0]) acc_r <= acc_r + a_r;
      a_r <= {a_r[bsc_pkg::WordW-2:0], 1'b0};
      b_r <= {1'b0, b_r[bsc_pkg::WordW-1:1]};
    end
  end

endmodule

FILE: src/bsc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on bsc_pkg. Divisor must be nonzero (checked by the caller).
module bsc_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [bsc_pkg::WordW-1:0] num,
  input  logic [bsc_pkg::WordW-1:0] den,
  output logic                     done,
  output logic [bsc_pkg::WordW-1:0] quot
);

  logic                      busy_r;
  logic [5:0]                cnt_r;
  logic [bsc_pkg::WordW-1:0] rem_r, quo_r, den_r;
  logic [bsc_pkg::WordW:0]   trial;
  logic                      fits;

  assign trial = {rem_r, quo_r[bsc_pkg::WordW-1]};
  assign fits  = trial >= {1'b0, den_r};
  assign done  = busy_r && (cnt_r == 6'(bsc_pkg::WordW));
  assign quot  = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (done) begin
      busy_r <= 1'b0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r && !done) begin
      rem_r <= fits ? 32'(trial - {1'b0, den_r}) : trial[bsc_pkg::WordW-1:0];
      quo_r <= {quo_r[bsc_pkg::WordW-2:0], fits};
    end
  end

endmodule

FILE: src/barometric_sensor_compensation.sv
// Barometric compensation top: config registers, step sequencer, serial mul/div.
// Depends on bsc_pkg, bsc_mul, bsc_div.
// Temperature takes one multiply and one divide on the serial units.
// Pressure takes ten multiplies and one divide.
// One item at a time; the steps share the bit-serial multiplier and divider.
// rst_n (synchronous, active low) clears config registers, temp term and control.
module barometric_sensor_compensation (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [23:0] raw_sample
  input  logic        in_tuser,   // [0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] value
  output logic [1:0]  out_tuser,  // [0] kind, [1] divide_fault
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  logic [1:0]  oss_r;
  logic [31:0] ac12_r, ac34_r, ac56_r, b12_r, mcmd_r;
  logic [31:0] temp_term_r, temp_term_nxt;

  bsc_pkg::state_t state_r, state_nxt;
  bsc_pkg::step_t  step_r, step_nxt;
  logic        act_r;
  logic [23:0] raw_r;
  logic [31:0] x1_r, x1_nxt, sq_r, sq_nxt, b3_r, b3_nxt, b4_r, b4_nxt;
  logic [31:0] b7_r, b7_nxt, p_r, p_nxt, val_r, val_nxt;
  logic        flt_r, flt_nxt;

  logic        mul_start, div_start, mul_done, div_done;
  logic [31:0] mul_a, mul_b, mul_p, div_n, div_d, div_q;

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  logic [31:0] b6, ut, up, den_t, num_t, x3, tq, b5;
  logic        is_div, res_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oss_r  <= '0;
      ac12_r <= '0;
      ac34_r <= '0;
      ac56_r <= '0;
      b12_r  <= '0;
      mcmd_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        bsc_pkg::REG_OSS:   oss_r  <= cfg_wdata[1:0];
        bsc_pkg::REG_AC1_2: ac12_r <= cfg_wdata;
        bsc_pkg::REG_AC3_4: ac34_r <= cfg_wdata;
        bsc_pkg::REG_AC5_6: ac56_r <= cfg_wdata;
        bsc_pkg::REG_B1_B2: b12_r  <= cfg_wdata;
        bsc_pkg::REG_MC_MD: mcmd_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign ac1 = bsc_pkg::hi_s(ac12_r);
  assign ac2 = bsc_pkg::lo_s(ac12_r);
  assign ac3 = bsc_pkg::hi_s(ac34_r);
  assign ac4 = {16'b0, ac34_r[15:0]};
  assign ac5 = {16'b0, ac56_r[31:16]};
  assign ac6 = {16'b0, ac56_r[15:0]};
  assign b1  = bsc_pkg::hi_s(b12_r);
  assign b2  = bsc_pkg::lo_s(b12_r);
  assign mc  = bsc_pkg::hi_s(mcmd_r);
  assign md  = bsc_pkg::lo_s(mcmd_r);

  assign b6    = temp_term_r - bsc_pkg::K_B6_OFS;
  assign ut    = {16'b0, raw_r[15:0]};
  assign up    = {8'b0, raw_r} >> (5'd8 - {3'b0, oss_r});
  assign den_t = x1_r + md;
  assign num_t = {mc[20:0], 11'b0};

  assign is_div = (step_r == bsc_pkg::ST_T_DIV) || (step_r == bsc_pkg::ST_P_DIV);
  assign res_ok = is_div ? div_done : mul_done;

  // operand select for the step being issued
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    div_n = '0;
    div_d = '0;
    case (step_r)
      bsc_pkg::ST_T_MUL: begin mul_a = ut - ac6; mul_b = ac5; end
      bsc_pkg::ST_T_DIV: begin
        div_n = num_t[31] ? 32'(0 - num_t) : num_t;
        div_d = den_t[31] ? 32'(0 - den_t) : den_t;
      end
      bsc_pkg::ST_P_SQ:  begin mul_a = b6;  mul_b = b6; end
      bsc_pkg::ST_P_X1:  begin mul_a = b2;  mul_b = sq_r; end
      bsc_pkg::ST_P_B3:  begin mul_a = ac2; mul_b = b6; end
      bsc_pkg::ST_P_X1B: begin mul_a = ac3; mul_b = b6; end
      bsc_pkg::ST_P_X2B: begin mul_a = b1;  mul_b = bsc_pkg::asr(sq_r, 5'd12); end
      bsc_pkg::ST_P_B4:  begin mul_a = ac4; mul_b = x1_r + bsc_pkg::K_B4_OFS; end
      bsc_pkg::ST_P_B7:  begin mul_a = up - b3_r; mul_b = bsc_pkg::K_B7_MUL >> oss_r; end
      bsc_pkg::ST_P_DIV: begin
        div_n = b7_r[31] ? b7_r : {b7_r[30:0], 1'b0};
        div_d = b4_r;
      end
      bsc_pkg::ST_P_SQP: begin
        mul_a = bsc_pkg::asr(p_r, 5'd8);
        mul_b = bsc_pkg::asr(p_r, 5'd8);
      end
      bsc_pkg::ST_P_X1C: begin mul_a = x1_r; mul_b = bsc_pkg::K_X1_MUL; end
      bsc_pkg::ST_P_X2C: begin mul_a = bsc_pkg::K_X2_MUL; mul_b = p_r; end
      default: ;
    endcase
  end

  assign mul_start = (state_r == bsc_pkg::S_ISSUE) && !is_div;
  assign div_start = (state_r == bsc_pkg::S_ISSUE) && is_div;

  bsc_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start),
    .op_a(mul_a), .op_b(mul_b), .done(mul_done), .prod(mul_p)
  );

  bsc_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(div_n), .den(div_d), .done(div_done), .quot(div_q)
  );

  assign tq = (num_t[31] ^ den_t[31]) ? 32'(0 - div_q) : div_q;
  assign b5 = x1_r + tq;
  assign x3 = x1_r + bsc_pkg::asr(mul_p, 5'd11);

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    x1_nxt        = x1_r;
    sq_nxt        = sq_r;
    b3_nxt        = b3_r;
    b4_nxt        = b4_r;
    b7_nxt        = b7_r;
    p_nxt         = p_r;
    val_nxt       = val_r;
    flt_nxt       = flt_r;
    temp_term_nxt = temp_term_r;
    unique case (state_r)
      bsc_pkg::S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = bsc_pkg::S_ISSUE;
          step_nxt  = in_tuser ? bsc_pkg::ST_P_SQ : bsc_pkg::ST_T_MUL;
          flt_nxt   = 1'b0;
        end
      end
      bsc_pkg::S_ISSUE: state_nxt = bsc_pkg::S_WAIT;
      bsc_pkg::S_WAIT: begin
        if (res_ok) begin
          state_nxt = bsc_pkg::S_ISSUE;
          step_nxt  = bsc_pkg::step_t'(step_r + 4'd1);
          case (step_r)
            bsc_pkg::ST_T_MUL: begin
              x1_nxt = bsc_pkg::asr(mul_p, 5'd15);
              if (bsc_pkg::asr(mul_p, 5'd15) + md == '0) begin
                val_nxt   = '0;
                flt_nxt   = 1'b1;
                state_nxt = bsc_pkg::S_OUT;
              end
            end
            bsc_pkg::ST_T_DIV: begin
              temp_term_nxt = b5;
              val_nxt       = bsc_pkg::asr(b5 + 32'd8, 5'd4);
              state_nxt     = bsc_pkg::S_OUT;
            end
            bsc_pkg::ST_P_SQ:  sq_nxt = mul_p;
            bsc_pkg::ST_P_X1:  x1_nxt = bsc_pkg::asr(mul_p, 5'd23);
            bsc_pkg::ST_P_B3:  b3_nxt = bsc_pkg::asr(((ac1 << 2) + x3 << oss_r) + 32'd2, 5'd2);
            bsc_pkg::ST_P_X1B: x1_nxt = bsc_pkg::asr(mul_p, 5'd13);
            bsc_pkg::ST_P_X2B: x1_nxt = bsc_pkg::asr(x1_r + bsc_pkg::asr(mul_p, 5'd16) + 32'd2,
                                                     5'd2);
            bsc_pkg::ST_P_B4:  b4_nxt = mul_p >> 15;
            bsc_pkg::ST_P_B7: begin
              b7_nxt = mul_p;
              if (b4_r == '0) begin
                val_nxt   = '0;
                flt_nxt   = 1'b1;
                state_nxt = bsc_pkg::S_OUT;
              end
            end
            bsc_pkg::ST_P_DIV: p_nxt  = b7_r[31] ? {div_q[30:0], 1'b0} : div_q;
            bsc_pkg::ST_P_SQP: x1_nxt = mul_p;
            bsc_pkg::ST_P_X1C: x1_nxt = bsc_pkg::asr(mul_p, 5'd16);
            bsc_pkg::ST_P_X2C: begin
              val_nxt   = p_r + bsc_pkg::asr(x1_r + bsc_pkg::asr(mul_p, 5'd16) + bsc_pkg::K_P_OFS,
                                             5'd4);
              state_nxt = bsc_pkg::S_OUT;
            end
            default: state_nxt = bsc_pkg::S_OUT;
          endcase
        end
      end
      bsc_pkg::S_OUT: begin
        if (!out_tvalid || out_tready) state_nxt = bsc_pkg::S_IDLE;
      end
      default: state_nxt = bsc_pkg::S_IDLE;
    endcase
  end

  assign in_tready = (state_r == bsc_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bsc_pkg::S_IDLE;
      step_r      <= bsc_pkg::ST_T_MUL;
      temp_term_r <= '0;
      out_tvalid  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      temp_term_r <= temp_term_nxt;
      if (state_r == bsc_pkg::S_OUT && (!out_tvalid || out_tready)) begin
        out_tvalid <= 1'b1;
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      raw_r <= in_tdata;
      act_r <= in_tuser;
    end
    x1_r  <= x1_nxt;
    sq_r  <= sq_nxt;
    b3_r  <= b3_nxt;
    b4_r  <= b4_nxt;
    b7_r  <= b7_nxt;
    p_r   <= p_nxt;
    val_r <= val_nxt;
    flt_r <= flt_nxt;
    if (state_r == bsc_pkg::S_OUT && (!out_tvalid || out_tready)) begin
      out_tdata <= val_r;
      out_tuser <= {flt_r, act_r};
    end
  end

endmodule
